FILE: design/pst_pkg.sv
// package for the profile statistics table
// types, codes and sizes shared by the controller, datapath and top level
package pst_pkg;

    localparam int unsigned TableEntries = 64;
    localparam int unsigned IdxW = $clog2(TableEntries);
    localparam int unsigned UsedW = IdxW + 1;
    localparam int unsigned StatW = 32 + 64 + 64 + 64 + 1;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_END   = 2'd1,
        OP_QUERY = 2'd2,
        OP_RESET = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_INACTIVE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_STAT_RD,
        S_STAT_WAIT,
        S_UPDATE,
        S_DIVIDE,
        S_OUT,
        S_CLEAR
    } t_state;

    // statistics record kept per entry
    typedef struct packed {
        logic        active;
        logic [31:0] count;
        logic [63:0] total;
        logic [63:0] min;
        logic [63:0] max;
    } t_stat;

    // controller to datapath
    typedef struct packed {
        logic            load_in;
        logic            key_rd;
        logic [IdxW-1:0] key_addr;
        logic            stat_rd;
        logic            alloc;
        logic            update;
        logic            div_start;
        logic            clear_wr;
        logic [IdxW-1:0] clear_addr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op            op;
        logic           key_match;
        logic [UsedW-1:0] used;
        logic           active;
        logic           div_busy;
    } t_sts;

endpackage

FILE: design/pst_if.sv
// valid/ready channel interfaces for the profile statistics table
// depends on nothing
interface pst_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] key;
    logic [63:0] now_ticks;
    modport source (output valid, operation, key, now_ticks, input ready);
    modport sink (input valid, operation, key, now_ticks, output ready);
endinterface

interface pst_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  entry_index;
    logic [31:0] call_count;
    logic [63:0] total_ticks;
    logic [63:0] min_ticks;
    logic [63:0] max_ticks;
    logic [63:0] average_ticks;
    modport source (output valid, status, entry_index, call_count, total_ticks,
                    min_ticks, max_ticks, average_ticks, input ready);
    modport sink (input valid, status, entry_index, call_count, total_ticks,
                  min_ticks, max_ticks, average_ticks, output ready);
endinterface

FILE: design/pst_ram.sv
// generic single-port ram with registered read
// depends on nothing
module pst_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end
endmodule

FILE: design/pst_div.sv
// 64 by 32 bit restoring divider, one quotient bit a cycle
// depends on nothing
module pst_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [63:0] o_quot
);
    logic [63:0] r_quot;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic [32:0] n_trial;
    logic [32:0] n_sh;

    always_comb begin
        n_sh    = {r_rem[31:0], r_quot[63]};
        n_trial = n_sh - {1'b0, r_den};
    end

    // shift-subtract iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt  <= 7'd64;
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_cnt != 7'd0) begin
            r_cnt <= r_cnt - 7'd1;
            if (!n_trial[32]) begin
                r_rem  <= n_trial;
                r_quot <= {r_quot[62:0], 1'b1};
            end else begin
                r_rem  <= n_sh;
                r_quot <= {r_quot[62:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != 7'd0);
    assign o_quot = r_quot;
endmodule

FILE: design/pst_ctrl.sv
// controller state machine for the profile statistics table
// depends on pst_pkg
module pst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  pst_pkg::t_sts i_sts,
    output pst_pkg::t_cmd o_cmd,
    output pst_pkg::t_status o_status,
    output logic          o_zero_stats
);
    pst_pkg::t_state r_state, n_state;
    logic [pst_pkg::UsedW-1:0] r_idx, n_idx;
    pst_pkg::t_status r_status, n_status;
    logic r_zero, n_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pst_pkg::S_IDLE;
            r_idx    <= '0;
            r_status <= pst_pkg::ST_OK;
            r_zero   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_status <= n_status;
            r_zero   <= n_zero;
        end
    end

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_status = r_status;
        n_zero   = r_zero;
        o_cmd    = '0;
        o_cmd.key_addr   = r_idx[pst_pkg::IdxW-1:0];
        o_cmd.clear_addr = r_idx[pst_pkg::IdxW-1:0];
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            pst_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_idx    = '0;
                    n_status = pst_pkg::ST_OK;
                    n_zero   = 1'b0;
                    n_state  = pst_pkg::S_SEARCH_RD;
                end
            end
            pst_pkg::S_SEARCH_RD: begin
                if (i_sts.op == pst_pkg::OP_RESET) begin
                    n_zero  = 1'b1;
                    n_state = pst_pkg::S_CLEAR;
                end else if (r_idx == i_sts.used) begin
                    if (i_sts.used == pst_pkg::UsedW'(pst_pkg::TableEntries)) begin
                        n_status = pst_pkg::ST_FULL;
                        n_zero   = 1'b1;
                        n_idx    = '0;
                        n_state  = pst_pkg::S_OUT;
                    end else begin
                        o_cmd.alloc = 1'b1;
                        n_state = pst_pkg::S_STAT_RD;
                    end
                end else begin
                    o_cmd.key_rd = 1'b1;
                    n_state = pst_pkg::S_SEARCH_CMP;
                end
            end
            pst_pkg::S_SEARCH_CMP: begin
                if (i_sts.key_match) begin
                    n_state = pst_pkg::S_STAT_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = pst_pkg::S_SEARCH_RD;
                end
            end
            pst_pkg::S_STAT_RD: begin
                o_cmd.stat_rd = 1'b1;
                n_state = pst_pkg::S_STAT_WAIT;
            end
            pst_pkg::S_STAT_WAIT: begin
                if (i_sts.op == pst_pkg::OP_END && !i_sts.active) begin
                    n_status = pst_pkg::ST_INACTIVE;
                    o_cmd.div_start = 1'b1;
                    n_state = pst_pkg::S_DIVIDE;
                end else if (i_sts.op == pst_pkg::OP_QUERY) begin
                    o_cmd.div_start = 1'b1;
                    n_state = pst_pkg::S_DIVIDE;
                end else begin
                    n_state = pst_pkg::S_UPDATE;
                end
            end
            pst_pkg::S_UPDATE: begin
                o_cmd.update    = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state = pst_pkg::S_DIVIDE;
            end
            pst_pkg::S_DIVIDE: begin
                if (!i_sts.div_busy) begin
                    n_state = pst_pkg::S_OUT;
                end
            end
            pst_pkg::S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (r_idx == pst_pkg::UsedW'(pst_pkg::TableEntries - 1)) begin
                    n_idx   = '0;
                    n_state = pst_pkg::S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            pst_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = pst_pkg::S_IDLE;
                end
            end
            default: n_state = pst_pkg::S_IDLE;
        endcase
    end

    assign o_status     = r_status;
    assign o_zero_stats = r_zero;
endmodule

FILE: design/pst_dp.sv
// datapath: key and statistics memories, update arithmetic and divider
// depends on pst_pkg, pst_ram and pst_div
module pst_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pst_pkg::t_cmd i_cmd,
    input  logic [1:0]    i_operation,
    input  logic [31:0]   i_key,
    input  logic [63:0]   i_now_ticks,
    input  logic          i_zero_stats,
    output pst_pkg::t_sts o_sts,
    output logic [5:0]    o_entry_index,
    output logic [31:0]   o_call_count,
    output logic [63:0]   o_total_ticks,
    output logic [63:0]   o_min_ticks,
    output logic [63:0]   o_max_ticks,
    output logic [63:0]   o_average_ticks
);
    localparam int unsigned IdxW = pst_pkg::IdxW;

    logic [1:0]  r_op;
    logic [31:0] r_key;
    logic [63:0] r_now;
    logic [63:0] r_start;
    logic [pst_pkg::UsedW-1:0] r_used;
    logic [IdxW-1:0] r_slot;
    pst_pkg::t_stat r_stat;
    logic [31:0] w_key_rd;
    pst_pkg::t_stat w_stat_rd;
    logic r_stat_pend;
    pst_pkg::t_stat n_stat;
    logic [63:0] n_elapsed;
    logic stat_we;
    logic [IdxW-1:0] stat_addr;
    pst_pkg::t_stat stat_wdata;
    logic div_busy;
    logic [63:0] div_quot;

    // key store
    pst_ram #(.Width(32), .Depth(pst_pkg::TableEntries)) u_keys (
        .i_clk  (i_clk),
        .i_we   (i_cmd.alloc),
        .i_re   (i_cmd.key_rd),
        .i_addr (i_cmd.alloc ? r_used[IdxW-1:0] : i_cmd.key_addr),
        .i_wdata(r_key),
        .o_rdata(w_key_rd)
    );

    // statistics store; alloc, update and clear share the write port
    always_comb begin
        stat_we    = i_cmd.alloc | i_cmd.update | i_cmd.clear_wr;
        stat_addr  = i_cmd.clear_wr ? i_cmd.clear_addr :
                     (i_cmd.alloc ? r_used[IdxW-1:0] : r_slot);
        stat_wdata = i_cmd.update ? n_stat : '0;
    end

    pst_ram #(.Width(pst_pkg::StatW), .Depth(pst_pkg::TableEntries)) u_stats (
        .i_clk  (i_clk),
        .i_we   (stat_we),
        .i_re   (i_cmd.stat_rd),
        .i_addr (stat_addr),
        .i_wdata(stat_wdata),
        .o_rdata(w_stat_rd)
    );

    // begin and end updates of the held record
    always_comb begin
        n_elapsed = r_now - r_start;
        n_stat    = r_stat;
        if (pst_pkg::t_op'(r_op) == pst_pkg::OP_BEGIN) begin
            n_stat.active = 1'b1;
        end else begin
            n_stat.active = 1'b0;
            n_stat.total  = r_stat.total + n_elapsed;
            if (r_stat.count != 32'hFFFF_FFFF) begin
                n_stat.count = r_stat.count + 32'd1;
            end
            if (r_stat.count == 32'd0 || n_elapsed < r_stat.min) begin
                n_stat.min = n_elapsed;
            end
            if (n_elapsed > r_stat.max) begin
                n_stat.max = n_elapsed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_start     <= '0;
            r_stat_pend <= 1'b0;
        end else begin
            r_stat_pend <= i_cmd.stat_rd;
            if (i_cmd.alloc) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.update && pst_pkg::t_op'(r_op) == pst_pkg::OP_BEGIN) begin
                r_start <= r_now;
            end
        end
    end

    // input word, slot and held record
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_operation;
            r_key <= i_key;
            r_now <= i_now_ticks;
        end
        if (i_cmd.key_rd) begin
            r_slot <= i_cmd.key_addr;
        end
        if (i_cmd.alloc) begin
            r_slot <= r_used[IdxW-1:0];
        end
        if (r_stat_pend) begin
            r_stat <= w_stat_rd;
        end else if (i_cmd.update) begin
            r_stat <= n_stat;
        end
    end

    // divider operands: updated record, fresh ram word, or held record
    pst_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (i_cmd.update ? n_stat.total :
                 (r_stat_pend ? w_stat_rd.total : r_stat.total)),
        .i_den  (i_cmd.update ? n_stat.count :
                 (r_stat_pend ? w_stat_rd.count : r_stat.count)),
        .o_busy (div_busy),
        .o_quot (div_quot)
    );

    always_comb begin
        o_sts.op        = pst_pkg::t_op'(r_op);
        o_sts.key_match = (w_key_rd == r_key);
        o_sts.used      = r_used;
        o_sts.active    = w_stat_rd.active;
        o_sts.div_busy  = div_busy;
    end

    // result word, zeroed for full and reset; min, max and average also zero with no calls
    always_comb begin
        o_entry_index   = i_zero_stats ? 6'd0 : 6'(r_slot);
        o_call_count    = i_zero_stats ? 32'd0 : r_stat.count;
        o_total_ticks   = i_zero_stats ? 64'd0 : r_stat.total;
        if (i_zero_stats || r_stat.count == 32'd0) begin
            o_min_ticks     = '0;
            o_max_ticks     = '0;
            o_average_ticks = '0;
        end else begin
            o_min_ticks     = r_stat.min;
            o_max_ticks     = r_stat.max;
            o_average_ticks = div_quot;
        end
    end
endmodule

FILE: design/profile_statistics_table_unit.sv
// top level of the profile statistics table
// depends on pst_pkg, pst_if, pst_ctrl and pst_dp
//
// usage:
//   one input word per operation (begin, end, query, reset stats) on i_in,
//   one result word per input word on o_out, valid/ready handshake.
//   one item at a time: the next word is taken once the result is taken.
// sequence:
//   lookup walks the used entries, a key ram read and a compare per entry,
//   then a statistics read and, for begin or for end of an active entry,
//   an update step; the average comes from a shift-subtract divider.
//   a reset-stats word sweeps all 64 entries, one per cycle.
//   a full-table miss returns after the search, with no divide.
// reset:
//   i_rst_n clears the controller, fill count and start time; the
//   statistics ram is cleared on allocation, so no clearing pass is needed.
// stall:
//   the result holds on o_out until taken; no new word is accepted meanwhile.
module profile_statistics_table_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    pst_in_if.sink    i_in,
    pst_out_if.source o_out
);
    pst_pkg::t_cmd    cmd;
    pst_pkg::t_sts    sts;
    pst_pkg::t_status status;
    logic             zero_stats;

    pst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_status    (status),
        .o_zero_stats(zero_stats)
    );

    pst_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_operation    (i_in.operation),
        .i_key          (i_in.key),
        .i_now_ticks    (i_in.now_ticks),
        .i_zero_stats   (zero_stats),
        .o_sts          (sts),
        .o_entry_index  (o_out.entry_index),
        .o_call_count   (o_out.call_count),
        .o_total_ticks  (o_out.total_ticks),
        .o_min_ticks    (o_out.min_ticks),
        .o_max_ticks    (o_out.max_ticks),
        .o_average_ticks(o_out.average_ticks)
    );

    assign o_out.status = status;
endmodule
